// ===== rtl/bffa_pkg.sv =====
// Shared types, constants and a helper function of the bitmap first-fit allocator.
`timescale 1ns / 1ps

package bffa_pkg;

   localparam int DEFAULT_MAP_BYTES = 512;
   localparam int MAP_WORD_BITS     = 64;
   localparam int BIT_POS_W         = 6;
   localparam int NUMBER_W          = 16;
   localparam int LIMIT_W           = 13;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 16;
   localparam int DEFAULT_ADDR_W    = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_START  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INODE_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_LIMIT = 2'd2;

   localparam logic [NUMBER_W-1:0] DATA_START_RESET  = 16'd0;
   localparam logic [LIMIT_W-1:0]  INODE_LIMIT_RESET = 13'd4096;
   localparam logic [LIMIT_W-1:0]  BLOCK_LIMIT_RESET = 13'd4096;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_FREE    = 1'b1;
   localparam logic POOL_INODE = 1'b0;
   localparam logic POOL_BLOCK = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_SUM,
      ST_ALLOC_WORD,
      ST_FREE_WORD,
      ST_RESP
   } state_type;

   // Position of the lowest clear bit of a map word.
   function automatic logic [BIT_POS_W-1:0] first_zero(input logic [MAP_WORD_BITS-1:0] w);
      logic [BIT_POS_W-1:0] pos;
      pos = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) begin
            pos = BIT_POS_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ===== rtl/bffa_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bffa_ram #(
   parameter int WIDTH  = bffa_pkg::MAP_WORD_BITS,
   parameter int ADDR_W = bffa_pkg::DEFAULT_ADDR_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bitmap_first_fit_allocator.sv =====
// Top level of the bitmap first-fit allocator with inode and data block pools.
// Allocate: the request passes ALLOC_SUM, ALLOC_WORD and RESP, then the result is registered.
// Free: the request passes FREE_WORD and RESP; a new request is taken only back in IDLE.
// The cost is set by dependent reads of the word-summary RAM and the bitmap RAM.
// After reset a clearing pass zeroes the bitmap RAM and fills the word-summary RAM, with entries
// past the end of the map marked full; requests are stalled meanwhile, configuration writes are taken.
`timescale 1ns / 1ps

module bitmap_first_fit_allocator #(
   parameter int MAP_BYTES = bffa_pkg::DEFAULT_MAP_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic                              req_pool,
   input  logic [bffa_pkg::NUMBER_W-1:0]     req_number,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bffa_pkg::NUMBER_W-1:0]     rsp_granted,
   output logic                              rsp_ok,
   input  logic                              csr_we,
   input  logic [bffa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bffa_pkg::CSR_DATA_W-1:0]   csr_data
);

   import bffa_pkg::*;

   localparam int MAP_BITS   = MAP_BYTES * 8;
   localparam int MAP_WORDS  = (MAP_BYTES + 7) / 8;
   localparam int NUM_GROUPS = (MAP_WORDS + 63) / 64;
   localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int NGP        = 2 ** GRP_W;
   localparam int IDX_W      = GRP_W + 2 * BIT_POS_W;
   localparam int CMP_W      = ((IDX_W > NUMBER_W) ? IDX_W : NUMBER_W) + 1;
   localparam int DA_W       = WORD_W + 1;
   localparam int SA_W       = GRP_W + 1;
   localparam int GW_W       = GRP_W + BIT_POS_W + 1;

   localparam logic [CMP_W-1:0] MAP_BITS_C  = CMP_W'(MAP_BITS);
   localparam logic [GW_W-1:0]  MAP_WORDS_C = GW_W'(MAP_WORDS);

   state_type state_ff, state_in;

   logic [DA_W-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [NUMBER_W-1:0]      data_start_ff;
   logic [LIMIT_W-1:0]       inode_limit_ff, block_limit_ff;

   logic                     pool_ff, pool_in;
   logic [GRP_W-1:0]         grp_ff, grp_in;
   logic [BIT_POS_W-1:0]     sub_ff, sub_in;
   logic [BIT_POS_W-1:0]     bit_ff, bit_in;
   logic [DA_W-1:0]          daddr_ff, daddr_in;
   logic [MAP_WORD_BITS-1:0] sum_ff, sum_in;
   logic [NUMBER_W-1:0]      res_granted_ff, res_granted_in;
   logic                     res_ok_ff, res_ok_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [NUMBER_W-1:0]      rsp_granted_ff, rsp_granted_in;
   logic                     rsp_ok_ff, rsp_ok_in;

   logic [NGP-1:0]           grp_full_ff [2];
   logic [NGP-1:0]           grp_full_in [2];

   logic                     data_we, sum_we;
   logic [DA_W-1:0]          data_waddr, data_raddr;
   logic [SA_W-1:0]          sum_waddr, sum_raddr;
   logic [MAP_WORD_BITS-1:0] data_wdata, sum_wdata, data_rdata, sum_rdata;

   logic                     accept, rsp_load;
   logic                     free_below, free_ok;
   logic [NUMBER_W-1:0]      free_idx;
   logic [WORD_W-1:0]        free_word;
   logic [GRP_W-1:0]         free_grp;
   logic [GRP_W-1:0]         alloc_grp;
   logic                     alloc_any;
   logic [BIT_POS_W-1:0]     alloc_sub, alloc_bit;
   logic [GRP_W+BIT_POS_W-1:0] alloc_word_wide;
   logic [IDX_W-1:0]         alloc_idx;
   logic [CMP_W-1:0]         alloc_idx_c, limit_c, result_c;
   logic                     alloc_ok;
   logic [MAP_WORD_BITS-1:0] new_word, new_sum, clr_sum;
   logic [GRP_W-1:0]         clr_grp;

   // Request side and free-number decode.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   assign free_below = (req_pool == POOL_BLOCK) && (req_number < data_start_ff);
   assign free_idx   = (req_pool == POOL_BLOCK) ? (req_number - data_start_ff) : req_number;
   assign free_ok    = !free_below && ({{(CMP_W-NUMBER_W){1'b0}}, free_idx} < MAP_BITS_C);
   assign free_word  = WORD_W'(free_idx[NUMBER_W-1:BIT_POS_W]);
   assign free_grp   = GRP_W'(free_idx[NUMBER_W-1:2*BIT_POS_W]);

   always_comb begin
      alloc_grp = '0;
      alloc_any = 1'b0;
      for (int i = NGP - 1; i >= 0; i--) begin
         if (!grp_full_ff[req_pool][i]) begin
            alloc_grp = GRP_W'(i);
            alloc_any = 1'b1;
         end
      end
   end

   // Allocation word and bit search.
   assign alloc_sub       = first_zero(sum_rdata);
   assign alloc_word_wide = {grp_ff, alloc_sub};
   assign alloc_bit       = first_zero(data_rdata);
   assign alloc_idx       = {grp_ff, sub_ff, alloc_bit};
   assign alloc_idx_c     = {{(CMP_W-IDX_W){1'b0}}, alloc_idx};
   assign limit_c         = (pool_ff == POOL_BLOCK)
                            ? {{(CMP_W-LIMIT_W){1'b0}}, block_limit_ff}
                            : {{(CMP_W-LIMIT_W){1'b0}}, inode_limit_ff};
   assign result_c        = (pool_ff == POOL_BLOCK)
                            ? ({{(CMP_W-NUMBER_W){1'b0}}, data_start_ff} + alloc_idx_c)
                            : alloc_idx_c;
   assign alloc_ok        = (alloc_idx_c < limit_c) && (alloc_idx_c < MAP_BITS_C)
                            && (result_c[CMP_W-1:NUMBER_W] == '0);
   assign new_word        = data_rdata | (MAP_WORD_BITS'(1) << alloc_bit);
   assign new_sum         = sum_ff | (MAP_WORD_BITS'(1) << sub_ff);

   // Summary entries of words past the end of the map read as full.
   assign clr_grp = clr_cnt_ff[GRP_W-1:0];
   always_comb begin
      for (int s = 0; s < MAP_WORD_BITS; s++) begin
         clr_sum[s] = ({1'b0, clr_grp, BIT_POS_W'(s)} >= MAP_WORDS_C);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_FREE) begin
                  state_in = free_ok ? ST_FREE_WORD : ST_RESP;
               end else begin
                  state_in = alloc_any ? ST_ALLOC_SUM : ST_RESP;
               end
            end
         end
         ST_ALLOC_SUM:  state_in = ST_ALLOC_WORD;
         ST_ALLOC_WORD: state_in = ST_RESP;
         ST_FREE_WORD:  state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      clr_cnt_in     = clr_cnt_ff;
      pool_in        = pool_ff;
      grp_in         = grp_ff;
      sub_in         = sub_ff;
      bit_in         = bit_ff;
      daddr_in       = daddr_ff;
      sum_in         = sum_ff;
      res_granted_in = res_granted_ff;
      res_ok_in      = res_ok_ff;
      grp_full_in    = grp_full_ff;
      data_we        = 1'b0;
      data_waddr     = daddr_ff;
      data_wdata     = '0;
      sum_we         = 1'b0;
      sum_waddr      = {pool_ff, grp_ff};
      sum_wdata      = '0;
      data_raddr     = {req_pool, free_word};
      sum_raddr      = {req_pool, (req_op == OP_FREE) ? free_grp : alloc_grp};

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            data_we    = 1'b1;
            data_waddr = clr_cnt_ff;
            data_wdata = '0;
            sum_we     = ((clr_cnt_ff >> SA_W) == '0);
            sum_waddr  = clr_cnt_ff[SA_W-1:0];
            sum_wdata  = clr_sum;
         end
         ST_IDLE: begin
            if (accept) begin
               pool_in        = req_pool;
               grp_in         = (req_op == OP_FREE) ? free_grp : alloc_grp;
               sub_in         = free_idx[2*BIT_POS_W-1:BIT_POS_W];
               bit_in         = free_idx[BIT_POS_W-1:0];
               daddr_in       = {req_pool, free_word};
               res_granted_in = '0;
               res_ok_in      = 1'b0;
            end
         end
         ST_ALLOC_SUM: begin
            sum_in     = sum_rdata;
            sub_in     = alloc_sub;
            daddr_in   = {pool_ff, alloc_word_wide[WORD_W-1:0]};
            data_raddr = {pool_ff, alloc_word_wide[WORD_W-1:0]};
         end
         ST_ALLOC_WORD: begin
            if (alloc_ok) begin
               res_granted_in = result_c[NUMBER_W-1:0];
               res_ok_in      = 1'b1;
               data_we        = 1'b1;
               data_wdata     = new_word;
               if (&new_word) begin
                  sum_we    = 1'b1;
                  sum_wdata = new_sum;
                  if (&new_sum) begin
                     grp_full_in[pool_ff][grp_ff] = 1'b1;
                  end
               end
            end
         end
         ST_FREE_WORD: begin
            res_ok_in  = 1'b1;
            data_we    = 1'b1;
            data_wdata = data_rdata & ~(MAP_WORD_BITS'(1) << bit_ff);
            sum_we     = 1'b1;
            sum_wdata  = sum_rdata & ~(MAP_WORD_BITS'(1) << sub_ff);
            grp_full_in[pool_ff][grp_ff] = 1'b0;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Result register.
   always_comb begin
      rsp_granted_in = rsp_granted_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = res_granted_ff;
         rsp_ok_in      = res_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         data_start_ff  <= DATA_START_RESET;
         inode_limit_ff <= INODE_LIMIT_RESET;
         block_limit_ff <= BLOCK_LIMIT_RESET;
         for (int p = 0; p < 2; p++) begin
            for (int g = 0; g < NGP; g++) begin
               grp_full_ff[p][g] <= (g * 64 >= MAP_WORDS);
            end
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         grp_full_ff  <= grp_full_in;
         if (csr_we) begin
            case (csr_index)
               CSR_DATA_START:  data_start_ff  <= csr_data;
               CSR_INODE_LIMIT: inode_limit_ff <= csr_data[LIMIT_W-1:0];
               CSR_BLOCK_LIMIT: block_limit_ff <= csr_data[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pool_ff        <= pool_in;
      grp_ff         <= grp_in;
      sub_ff         <= sub_in;
      bit_ff         <= bit_in;
      daddr_ff       <= daddr_in;
      sum_ff         <= sum_in;
      res_granted_ff <= res_granted_in;
      res_ok_ff      <= res_ok_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_ok_ff      <= rsp_ok_in;
   end

   bffa_ram #(
      .WIDTH  (MAP_WORD_BITS),
      .ADDR_W (DA_W)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_waddr),
      .wr_data (data_wdata),
      .rd_addr (data_raddr),
      .rd_data (data_rdata)
   );

   bffa_ram #(
      .WIDTH  (MAP_WORD_BITS),
      .ADDR_W (SA_W)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_addr (sum_raddr),
      .rd_data (sum_rdata)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_ok      = rsp_ok_ff;

`ifndef NO_ASSERTIONS
   // The group summary must never point at a summary entry that is all full.
   a_sum_not_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC_SUM) |-> !(&sum_rdata))
      else $error("selected summary entry has no free word");

   // The word summary must never point at a bitmap word that is all used.
   a_word_not_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC_WORD) |-> !(&data_rdata))
      else $error("selected bitmap word has no free bit");

   // No transaction leaves the block before the clearing pass is over.
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response during clearing pass");

   // A refused request always reports zero.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_granted_ff == '0))
      else $error("nonzero number on a refused request");
`endif

endmodule
